FILE: rtl/core/clock_sweep_buffer_pool_macros.svh
// assertion macros for the buffer pool
`ifndef CLOCK_SWEEP_BUFFER_POOL_MACROS_SVH
`define CLOCK_SWEEP_BUFFER_POOL_MACROS_SVH

// property holds at every clock edge outside reset
`define CSBP_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("csbp assertion failed");

// antecedent implies consequent in the next cycle
`define CSBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csbp assertion failed");

`endif

FILE: rtl/core/csbp_pkg.sv
// shared constants and types of the buffer pool
package csbp_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int USAGE_CAP_DEF = 4;
  localparam int PIN_BITS_DEF  = 8;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int USAGE_W  = 3;
  localparam int PIN_W    = 8;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNPIN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREE       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EVICTED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BUMP,
    OP_SETVAL,
    OP_WRITE,
    OP_UNPIN,
    OP_DECAY
  } cell_op_e;

  typedef struct packed {
    logic     en;
    cell_op_e op;
  } cell_cmd_t;

endpackage

FILE: rtl/core/csbp_req_if.sv
// request channel of the buffer pool
interface csbp_req_if;
  logic                           valid;
  logic                           ready;
  logic [csbp_pkg::MODE_W-1:0]    mode;
  logic [csbp_pkg::KEY_W-1:0]     key;
  logic [csbp_pkg::VALUE_W-1:0]   value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

FILE: rtl/core/csbp_rsp_if.sv
// response channel of the buffer pool
interface csbp_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [csbp_pkg::STATUS_W-1:0]   status;
  logic [csbp_pkg::VALUE_W-1:0]    read_value;
  logic [csbp_pkg::SLOT_W-1:0]     slot;
  logic [csbp_pkg::KEY_W-1:0]      evicted_key;
  logic [csbp_pkg::USAGE_W-1:0]    usage_after;
  logic [csbp_pkg::PIN_W-1:0]      pin_after;
  logic [csbp_pkg::CNT_W-1:0]      hit_total;
  logic [csbp_pkg::CNT_W-1:0]      miss_total;

  modport source (output valid, status, read_value, slot, evicted_key, usage_after,
                  pin_after, hit_total, miss_total, input ready);
  modport sink   (input valid, status, read_value, slot, evicted_key, usage_after,
                  pin_after, hit_total, miss_total, output ready);
endinterface

FILE: rtl/core/clock_sweep_buffer_pool.sv
// top level of the clock sweep buffer pool
//
// Requests arrive on req_i (mode, key, value) and each produces exactly one
// response on rsp_o, in order. One transaction is in flight at a time; the
// request side is ready only while the sequencer is idle.
// A get, an update put, a free frame put or an unpin is accepted in the idle
// state and goes through the lookup along the frame row and the result state
// to the response register. An evicting put then sweeps the clock hand over
// the frames, at most (USAGE_CAP+1)*filled+1 visits, and when every frame is
// pinned it ends with ST_ALL_PINNED; the hand loop through the frame row sets
// that bound. The frames_in_use register is written through
// cfg_we_i/cfg_data_i; the user must write it only while the block is idle,
// which the block itself does not enforce; 0 acts as 1 and values above
// FRAMES act as FRAMES. Reset clears usage and pin counts, fill level, hand,
// hit and miss totals and sets frames_in_use to 16; no clearing pass is
// needed. The response is held in an output register; when the receiver
// stalls the finished result waits there and the next request may already
// be taken, but its own result waits until the register is free.
`include "clock_sweep_buffer_pool_macros.svh"
module clock_sweep_buffer_pool #(
  parameter int FRAMES    = csbp_pkg::FRAMES_DEF,
  parameter int USAGE_CAP = csbp_pkg::USAGE_CAP_DEF,
  parameter int PIN_BITS  = csbp_pkg::PIN_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  csbp_req_if.sink                     req_i,
  csbp_rsp_if.source                   rsp_o,
  input  logic                         cfg_we_i,
  input  logic [csbp_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int UW = $clog2(USAGE_CAP + 1);
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FW = $clog2(FRAMES + 1);
  localparam int LW = $clog2((USAGE_CAP + 1) * FRAMES + 2);
  localparam int KW = csbp_pkg::KEY_W;
  localparam int VW = csbp_pkg::VALUE_W;
  localparam int SW = csbp_pkg::SLOT_W;
  localparam int OUW = csbp_pkg::USAGE_W;
  localparam int OPW = csbp_pkg::PIN_W;
  localparam int CNW = csbp_pkg::CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [csbp_pkg::CFG_W-1:0]     cfg_q;
  logic [csbp_pkg::MODE_W-1:0]    mode_q;
  logic [KW-1:0]                  key_q;
  logic [VW-1:0]                  value_q;
  logic [FW-1:0]                  filled_q, filled_d;
  logic [IW-1:0]                  hand_q, hand_d;
  logic [LW-1:0]                  lim_q, lim_d, limit_q, limit_d;
  logic [CNW-1:0]                 hits_q, hits_d, misses_q, misses_d;
  logic [csbp_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [VW-1:0]                  rval_q, rval_d;
  logic [IW-1:0]                  slot_q, slot_d;
  logic [KW-1:0]                  ekey_q, ekey_d;
  logic                           touched_q, touched_d;
  logic                           out_valid_q;
  logic                           load_out;

  csbp_pkg::cell_op_e             op;
  logic [IW-1:0]                  target;
  csbp_pkg::cell_cmd_t            cmd [FRAMES];
  logic [FRAMES:0]                chain;
  logic [FRAMES-1:0]              sel;
  logic [KW-1:0]                  key_arr [FRAMES];
  logic [VW-1:0]                  val_arr [FRAMES];
  logic [UW-1:0]                  use_arr [FRAMES];
  logic [PIN_BITS-1:0]            pin_arr [FRAMES];
  logic [IW-1:0]                  hit_idx;
  logic                           hit;
  logic                           has_room;
  logic [IW-1:0]                  hand_start, hand_next;

  assign chain[0] = 1'b0;
  assign hit      = chain[FRAMES];

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign cmd[i].en = (op != csbp_pkg::OP_NONE) && (target == IW'(i));
    assign cmd[i].op = op;
    csbp_cell #(
      .USAGE_CAP (USAGE_CAP),
      .PIN_BITS  (PIN_BITS),
      .UW        (UW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd[i]),
      .live_i      (FW'(i) < filled_q),
      .probe_key_i (key_q),
      .wr_value_i  (value_q),
      .hit_prev_i  (chain[i]),
      .hit_next_o  (chain[i+1]),
      .sel_o       (sel[i]),
      .key_o       (key_arr[i]),
      .value_o     (val_arr[i]),
      .usage_o     (use_arr[i]),
      .pin_o       (pin_arr[i])
    );
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (sel[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  always_comb begin
    int cap;
    cap = int'(cfg_q);
    if (cap == 0) cap = 1;
    if (cap > FRAMES) cap = FRAMES;
    has_room = int'(filled_q) < cap;
  end

  assign hand_start = (FW'(hand_q) >= filled_q) ? '0 : hand_q;
  assign hand_next  = ((FW'(hand_q) + FW'(1)) == filled_q) ? '0 : hand_q + IW'(1);
  assign load_out   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    filled_d  = filled_q;
    hand_d    = hand_q;
    lim_d     = lim_q;
    limit_d   = limit_q;
    hits_d    = hits_q;
    misses_d  = misses_q;
    status_d  = status_q;
    rval_d    = rval_q;
    slot_d    = slot_q;
    ekey_d    = ekey_q;
    touched_d = touched_q;
    op        = csbp_pkg::OP_NONE;
    target    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_LOOK;
      end
      S_LOOK: begin
        status_d  = csbp_pkg::ST_NOT_FOUND;
        rval_d    = '0;
        slot_d    = '0;
        ekey_d    = '0;
        touched_d = 1'b0;
        state_d   = S_DONE;
        target    = hit_idx;
        case (mode_q)
          csbp_pkg::MODE_GET: begin
            if (hit) begin
              op        = csbp_pkg::OP_BUMP;
              status_d  = csbp_pkg::ST_FOUND;
              rval_d    = val_arr[hit_idx];
              slot_d    = hit_idx;
              touched_d = 1'b1;
              if (hits_q != '1) hits_d = hits_q + CNW'(1);
            end else if (misses_q != '1) begin
              misses_d = misses_q + CNW'(1);
            end
          end
          csbp_pkg::MODE_PUT: begin
            if (hit) begin
              op        = csbp_pkg::OP_SETVAL;
              status_d  = csbp_pkg::ST_FOUND;
              slot_d    = hit_idx;
              touched_d = 1'b1;
            end else if (has_room) begin
              op        = csbp_pkg::OP_WRITE;
              target    = IW'(filled_q);
              status_d  = csbp_pkg::ST_FREE;
              slot_d    = IW'(filled_q);
              touched_d = 1'b1;
              filled_d  = filled_q + FW'(1);
            end else begin
              hand_d  = hand_start;
              lim_d   = '0;
              limit_d = LW'(USAGE_CAP + 1) * LW'(filled_q) + LW'(1);
              state_d = S_SWEEP;
            end
          end
          csbp_pkg::MODE_UNPIN: begin
            if (hit) begin
              op        = csbp_pkg::OP_UNPIN;
              status_d  = csbp_pkg::ST_FOUND;
              slot_d    = hit_idx;
              touched_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        target = hand_q;
        if (lim_q == limit_q) begin
          status_d = csbp_pkg::ST_ALL_PINNED;
          state_d  = S_DONE;
        end else begin
          lim_d  = lim_q + LW'(1);
          hand_d = hand_next;
          if (pin_arr[hand_q] != '0) begin
            op = csbp_pkg::OP_NONE;
          end else if (use_arr[hand_q] != '0) begin
            op = csbp_pkg::OP_DECAY;
          end else begin
            op        = csbp_pkg::OP_WRITE;
            status_d  = csbp_pkg::ST_EVICTED;
            slot_d    = hand_q;
            ekey_d    = key_arr[hand_q];
            touched_d = 1'b1;
            state_d   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= csbp_pkg::CFG_RESET;
      filled_q    <= '0;
      hand_q      <= '0;
      lim_q       <= '0;
      limit_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
      hand_q   <= hand_d;
      lim_q    <= lim_d;
      limit_q  <= limit_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (state_q == S_DONE && load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q  <= req_i.mode;
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end
    status_q  <= status_d;
    rval_q    <= rval_d;
    slot_q    <= slot_d;
    ekey_q    <= ekey_d;
    touched_q <= touched_d;
    if (state_q == S_DONE && load_out) begin
      rsp_o.status      <= status_q;
      rsp_o.read_value  <= rval_q;
      rsp_o.slot        <= SW'(slot_q);
      rsp_o.evicted_key <= ekey_q;
      rsp_o.usage_after <= touched_q ? OUW'(use_arr[slot_q]) : '0;
      rsp_o.pin_after   <= touched_q ? OPW'(pin_arr[slot_q]) : '0;
      rsp_o.hit_total   <= hits_q;
      rsp_o.miss_total  <= misses_q;
    end
  end

  assign rsp_o.valid = out_valid_q;

  `CSBP_ASSERT(a_fill_bound, filled_q <= FW'(FRAMES))
  `CSBP_ASSERT(a_sweep_bound, (state_q != S_SWEEP) || (lim_q <= limit_q))
  `CSBP_ASSERT_NEXT(a_accept_look, req_i.valid && req_i.ready, state_q == S_LOOK)
  `CSBP_ASSERT(a_pinned_clean,
               !(rsp_o.valid && rsp_o.status == csbp_pkg::ST_ALL_PINNED) || rsp_o.slot == '0)

endmodule

FILE: rtl/core/csbp_cell.sv
// one pool frame: key, value, usage and pin count, with a match chain link
module csbp_cell #(
  parameter int USAGE_CAP = csbp_pkg::USAGE_CAP_DEF,
  parameter int PIN_BITS  = csbp_pkg::PIN_BITS_DEF,
  parameter int UW        = $clog2(USAGE_CAP + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  csbp_pkg::cell_cmd_t            cmd_i,
  input  logic                           live_i,
  input  logic [csbp_pkg::KEY_W-1:0]     probe_key_i,
  input  logic [csbp_pkg::VALUE_W-1:0]   wr_value_i,
  input  logic                           hit_prev_i,
  output logic                           hit_next_o,
  output logic                           sel_o,
  output logic [csbp_pkg::KEY_W-1:0]     key_o,
  output logic [csbp_pkg::VALUE_W-1:0]   value_o,
  output logic [UW-1:0]                  usage_o,
  output logic [PIN_BITS-1:0]            pin_o
);

  logic [csbp_pkg::KEY_W-1:0]   key_q, key_d;
  logic [csbp_pkg::VALUE_W-1:0] value_q, value_d;
  logic [UW-1:0]                usage_q, usage_d;
  logic [PIN_BITS-1:0]          pin_q, pin_d;
  logic                         match;

  assign match      = live_i && (key_q == probe_key_i);
  assign sel_o      = match && !hit_prev_i;
  assign hit_next_o = hit_prev_i || match;
  assign key_o      = key_q;
  assign value_o    = value_q;
  assign usage_o    = usage_q;
  assign pin_o      = pin_q;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    usage_d = usage_q;
    pin_d   = pin_q;
    if (cmd_i.en) begin
      case (cmd_i.op)
        csbp_pkg::OP_BUMP, csbp_pkg::OP_SETVAL: begin
          if (usage_q < UW'(USAGE_CAP)) usage_d = usage_q + UW'(1);
          if (pin_q != {PIN_BITS{1'b1}}) pin_d = pin_q + PIN_BITS'(1);
          if (cmd_i.op == csbp_pkg::OP_SETVAL) value_d = wr_value_i;
        end
        csbp_pkg::OP_WRITE: begin
          key_d   = probe_key_i;
          value_d = wr_value_i;
          usage_d = UW'(1);
          pin_d   = PIN_BITS'(1);
        end
        csbp_pkg::OP_UNPIN: begin
          if (pin_q != '0) pin_d = pin_q - PIN_BITS'(1);
        end
        csbp_pkg::OP_DECAY: begin
          if (usage_q != '0) usage_d = usage_q - UW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_q <= '0;
      pin_q   <= '0;
    end else begin
      usage_q <= usage_d;
      pin_q   <= pin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

FILE: test/testbench.sv
// self-checking testbench of the clock sweep buffer pool, driven and checked by handshake
module testbench;

  typedef struct packed {
    logic [csbp_pkg::MODE_W-1:0]  mode;
    logic [csbp_pkg::KEY_W-1:0]   key;
    logic [csbp_pkg::VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [csbp_pkg::STATUS_W-1:0] status;
    logic [csbp_pkg::VALUE_W-1:0]  read_value;
    logic [csbp_pkg::SLOT_W-1:0]   slot;
    logic [csbp_pkg::KEY_W-1:0]    evicted_key;
    logic [csbp_pkg::USAGE_W-1:0]  usage_after;
    logic [csbp_pkg::PIN_W-1:0]    pin_after;
    logic [csbp_pkg::CNT_W-1:0]    hit_total;
    logic [csbp_pkg::CNT_W-1:0]    miss_total;
  } response_t;

  localparam int NFR = csbp_pkg::FRAMES_DEF;
  localparam int UCAP = csbp_pkg::USAGE_CAP_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [csbp_pkg::CFG_W-1:0] cfg_data_i = csbp_pkg::CFG_RESET;

  csbp_req_if req_if ();
  csbp_rsp_if rsp_if ();

  clock_sweep_buffer_pool dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // pool mirror
  logic [csbp_pkg::KEY_W-1:0]   pool_keys   [NFR];
  logic [csbp_pkg::VALUE_W-1:0] pool_values [NFR];
  int unsigned                  pool_usage  [NFR];
  int unsigned                  pool_pins   [NFR];
  int unsigned                  pool_filled;
  int unsigned                  pool_hand;
  logic [csbp_pkg::CNT_W-1:0]   pool_hits;
  logic [csbp_pkg::CNT_W-1:0]   pool_misses;
  logic [csbp_pkg::CFG_W-1:0]   pool_capacity;

  request_t  pending_reqs [$];
  response_t expected_rsps [$];
  logic [csbp_pkg::KEY_W-1:0] used_keys [$];
  int errors = 0;
  int send_idle_pct = 18;
  int recv_idle_pct = 76;
  logic req_taken = 1'b0;
  logic hold_arm = 1'b0;
  logic hold_used = 1'b0;
  int hold_cnt = 0;

  function automatic response_t pool_step(request_t rq);
    response_t r;
    int found;
    int victim;
    int unsigned cap;
    int unsigned limit;
    int unsigned cur;
    bit touched;
    r = '0;
    r.status = csbp_pkg::ST_NOT_FOUND;
    found = -1;
    victim = -1;
    touched = 0;
    for (int i = 0; i < int'(pool_filled); i++)
      if (found < 0 && pool_keys[i] == rq.key) found = i;
    cap = (pool_capacity == 0) ? 1 : (pool_capacity > NFR ? NFR : pool_capacity);
    if (rq.mode == csbp_pkg::MODE_GET) begin
      if (found >= 0) begin
        if (pool_usage[found] < UCAP) pool_usage[found]++;
        if (pool_pins[found] < 255) pool_pins[found]++;
        if (pool_hits != '1) pool_hits++;
        r.status = csbp_pkg::ST_FOUND;
        r.read_value = pool_values[found];
        r.slot = csbp_pkg::SLOT_W'(found);
        touched = 1;
      end else if (pool_misses != '1) begin
        pool_misses++;
      end
    end else if (rq.mode == csbp_pkg::MODE_PUT) begin
      if (found >= 0) begin
        if (pool_usage[found] < UCAP) pool_usage[found]++;
        if (pool_pins[found] < 255) pool_pins[found]++;
        pool_values[found] = rq.value;
        r.status = csbp_pkg::ST_FOUND;
        r.slot = csbp_pkg::SLOT_W'(found);
        touched = 1;
      end else if (pool_filled < cap) begin
        r.slot = csbp_pkg::SLOT_W'(pool_filled);
        pool_keys[pool_filled] = rq.key;
        pool_values[pool_filled] = rq.value;
        pool_usage[pool_filled] = 1;
        pool_pins[pool_filled] = 1;
        pool_filled++;
        r.status = csbp_pkg::ST_FREE;
        touched = 1;
      end else begin
        if (pool_hand >= pool_filled) pool_hand = 0;
        limit = (UCAP + 1) * pool_filled + 1;
        for (int unsigned s = 0; s < limit && victim < 0; s++) begin
          cur = pool_hand;
          pool_hand = (pool_hand + 1) % pool_filled;
          if (pool_pins[cur] > 0) continue;
          if (pool_usage[cur] > 0) begin
            pool_usage[cur]--;
            continue;
          end
          victim = cur;
        end
        if (victim >= 0) begin
          r.slot = csbp_pkg::SLOT_W'(victim);
          r.evicted_key = pool_keys[victim];
          pool_keys[victim] = rq.key;
          pool_values[victim] = rq.value;
          pool_usage[victim] = 1;
          pool_pins[victim] = 1;
          r.status = csbp_pkg::ST_EVICTED;
          touched = 1;
        end else begin
          r.status = csbp_pkg::ST_ALL_PINNED;
        end
      end
    end else if (rq.mode == csbp_pkg::MODE_UNPIN) begin
      if (found >= 0) begin
        if (pool_pins[found] > 0) pool_pins[found]--;
        r.status = csbp_pkg::ST_FOUND;
        r.slot = csbp_pkg::SLOT_W'(found);
        touched = 1;
      end
    end
    if (touched) begin
      r.usage_after = csbp_pkg::USAGE_W'(pool_usage[r.slot]);
      r.pin_after = csbp_pkg::PIN_W'(pool_pins[r.slot]);
    end
    r.hit_total = pool_hits;
    r.miss_total = pool_misses;
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= '0;
      req_if.key <= '0;
      req_if.value <= '0;
    end else if (!req_if.valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        {req_if.mode, req_if.key, req_if.value} <= pending_reqs.pop_front();
        req_if.valid <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= 300;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    request_t rq;
    response_t got;
    response_t exp_r;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        rq = {req_if.mode, req_if.key, req_if.value};
        expected_rsps = {expected_rsps, pool_step(rq)};
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.status, rsp_if.read_value, rsp_if.slot, rsp_if.evicted_key,
               rsp_if.usage_after, rsp_if.pin_after, rsp_if.hit_total, rsp_if.miss_total};
        if (expected_rsps.size() == 0) begin
          $error("unexpected transaction status %0d", got.status);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.read_value !== exp_r.read_value) begin
            $error("read_value exp %h got %h", exp_r.read_value, got.read_value); errors++;
          end
          if (got.slot !== exp_r.slot) begin
            $error("slot exp %0d got %0d", exp_r.slot, got.slot); errors++;
          end
          if (got.evicted_key !== exp_r.evicted_key) begin
            $error("evicted_key exp %h got %h", exp_r.evicted_key, got.evicted_key);
            errors++;
          end
          if (got.usage_after !== exp_r.usage_after) begin
            $error("usage_after exp %0d got %0d", exp_r.usage_after, got.usage_after);
            errors++;
          end
          if (got.pin_after !== exp_r.pin_after) begin
            $error("pin_after exp %0d got %0d", exp_r.pin_after, got.pin_after); errors++;
          end
          if (got.hit_total !== exp_r.hit_total) begin
            $error("hit_total exp %0d got %0d", exp_r.hit_total, got.hit_total); errors++;
          end
          if (got.miss_total !== exp_r.miss_total) begin
            $error("miss_total exp %0d got %0d", exp_r.miss_total, got.miss_total);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [csbp_pkg::KEY_W-1:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(99) < 75)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    return $urandom();
  endfunction

  task automatic queue_req(logic [csbp_pkg::MODE_W-1:0] m, logic [csbp_pkg::KEY_W-1:0] k,
                           logic [csbp_pkg::VALUE_W-1:0] v);
    request_t rq;
    rq.mode = m;
    rq.key = k;
    rq.value = v;
    pending_reqs = {pending_reqs, rq};
    if (m == csbp_pkg::MODE_PUT && used_keys.size() < 40) used_keys = {used_keys, k};
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [csbp_pkg::CFG_W-1:0] c);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pool_capacity = c;
  endtask

  task automatic random_phase(int count);
    int r;
    logic [csbp_pkg::MODE_W-1:0] m;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      m = r < 40 ? csbp_pkg::MODE_GET : (r < 75 ? csbp_pkg::MODE_PUT :
          (r < 97 ? csbp_pkg::MODE_UNPIN : csbp_pkg::MODE_UNKNOWN));
      queue_req(m, pick_key(), $urandom());
    end
  endtask

  initial begin
    logic [csbp_pkg::CFG_W-1:0] caps [6];
    for (int i = 0; i < NFR; i++) begin
      pool_keys[i] = '0;
      pool_values[i] = '0;
      pool_usage[i] = 0;
      pool_pins[i] = 0;
    end
    pool_filled = 0;
    pool_hand = 0;
    pool_hits = '0;
    pool_misses = '0;
    pool_capacity = csbp_pkg::CFG_RESET;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: small pool, extremes, all pinned, unpin, unknown mode
    set_capacity(5'd2);
    queue_req(csbp_pkg::MODE_GET, '0, '0);
    queue_req(csbp_pkg::MODE_PUT, '0, '1);
    queue_req(csbp_pkg::MODE_PUT, '1, '0);
    queue_req(csbp_pkg::MODE_GET, '0, '0);
    queue_req(csbp_pkg::MODE_GET, '1, '0);
    queue_req(csbp_pkg::MODE_PUT, 32'h5555_aaaa, 32'h1234);
    queue_req(csbp_pkg::MODE_UNPIN, '0, '0);
    queue_req(csbp_pkg::MODE_UNPIN, '0, '0);
    queue_req(csbp_pkg::MODE_UNPIN, '0, '0);
    queue_req(csbp_pkg::MODE_UNPIN, '0, '0);
    queue_req(csbp_pkg::MODE_PUT, 32'haaaa_5555, '1);
    queue_req(csbp_pkg::MODE_PUT, '0, 32'h77);
    queue_req(csbp_pkg::MODE_UNPIN, 32'h0bad_0bad, '0);
    queue_req(csbp_pkg::MODE_UNKNOWN, '1, '1);
    queue_req(csbp_pkg::MODE_PUT, '1, 32'h1);
    queue_req(csbp_pkg::MODE_GET, 32'haaaa_5555, '0);
    drain();

    // pin saturation: bump one key past 255
    set_capacity(5'd16);
    for (int i = 0; i < 260; i++) queue_req(csbp_pkg::MODE_GET, '1, '0);
    drain();

    caps = '{5'd0, 5'd1, 5'd4, 5'd31, 5'd16, 5'd8};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 18;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_capacity(caps[ph]);
      if (ph == 3) hold_arm = 1'b1;
      random_phase(280);
      drain();
    end

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
